// ===== design/srmcdr_pkg.sv =====
// Shared constants for the switched reluctance commutation and duty ramp block.
package srmcdr_pkg;

  // Phase codes carried on active_phase.
  localparam logic [1:0] PH_A   = 2'd0;
  localparam logic [1:0] PH_B   = 2'd1;
  localparam logic [1:0] PH_C   = 2'd2;
  localparam logic [1:0] PH_OFF = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_DUTY_LIMIT = 2'd0;
  localparam logic [1:0] REG_RAMP_STEP  = 2'd1;
  localparam logic [1:0] REG_PERIOD     = 2'd2;

  localparam logic [6:0]  DUTY_LIMIT_RST = 7'd15;
  localparam logic [6:0]  RAMP_STEP_RST  = 7'd1;
  localparam logic [15:0] PERIOD_RST     = 16'd5999;
  localparam logic [6:0]  DUTY_MAX       = 7'd100;

  // Number parser phases.
  localparam logic [1:0] NP_SKIP  = 2'd0;
  localparam logic [1:0] NP_SIGN  = 2'd1;
  localparam logic [1:0] NP_DIGIT = 2'd2;
  localparam logic [1:0] NP_DONE  = 2'd3;

  // Characters of the command line.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;

  localparam logic [7:0] NUM_SAT = 8'd255;

  // Division of the duty-period product by 100: q = (p * DIV100_RECIP) >> DIV100_SHIFT,
  // exact for every product below 2^23.
  localparam int unsigned        PROD_W       = 23;
  localparam int unsigned        DIV100_SHIFT = 30;
  localparam logic [23:0]        DIV100_RECIP = 24'd10737419;

endpackage

// ===== design/srm_commutation_duty_ramp_core.sv =====
// Top level: sensor commutation, duty ramp, serial command parser and compare pipeline.
// A tick request reaches its result through an input stage, a duty-period multiply
// stage and a reciprocal multiply stage. Throughput: one request per cycle unless the
// output stalls; serial byte requests give no result. Each stage moves on when the one
// after it frees. Reset (rst_ni low, asynchronous) disarms, clears duty, target and
// line state, turns the phase off and loads the register defaults.
module srm_commutation_duty_ramp_core #(
  parameter int LINE_CHARS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic        sensor_one_i,
  input  logic        sensor_two_i,
  input  logic        sensor_three_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] compare_phase_a_o,
  output logic [15:0] compare_phase_b_o,
  output logic [15:0] compare_phase_c_o,
  output logic [1:0]  active_phase_o,
  output logic [6:0]  duty_now_o,
  output logic        is_armed_o
);

  localparam int LenW = $clog2(LINE_CHARS + 1);
  localparam int PW   = srmcdr_pkg::PROD_W;
  localparam int QW   = PW + 24;

  // Configuration registers
  logic [6:0]  duty_limit_q, ramp_step_q;
  logic [15:0] period_q;

  // Control state
  logic            armed_q, armed_d;
  logic [6:0]      target_q, target_d;
  logic [6:0]      duty_q, duty_d;
  logic [1:0]      phase_mem_q, phase_mem_d;
  logic [LenW-1:0] len_q, len_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic [7:0]      acc_q, acc_d;
  logic [1:0]      np_q, np_d;
  logic            neg_q, neg_d;

  // Pipeline
  logic           s1_v_q, s2_v_q, out_v_q;
  logic           ready_a, ready_b, ready_c, in_fire;
  logic [1:0]     s1_phase_q, s2_phase_q;
  logic [6:0]     s1_duty_q, s2_duty_q;
  logic           s1_armed_q, s2_armed_q;
  logic [PW-1:0]  s2_prod_q;
  logic [QW-1:0]  quot_full;
  logic [15:0]    cmp;

  // Tick path
  logic       sens_any;
  logic [1:0] tick_phase;
  logic [7:0] base8, tgt8, step8, up8, dn8, ramp8;

  // Serial path
  logic       is_eol, is_digit, is_ws, is_sign;
  logic [11:0] acc_next;

  assign ready_c    = !out_v_q || out_ready_i;
  assign ready_b    = !s2_v_q || ready_c;
  assign ready_a    = !s1_v_q || ready_b;
  assign in_ready_o = ready_a;
  assign in_fire    = in_valid_i && ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_limit_q <= srmcdr_pkg::DUTY_LIMIT_RST;
      ramp_step_q  <= srmcdr_pkg::RAMP_STEP_RST;
      period_q     <= srmcdr_pkg::PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srmcdr_pkg::REG_DUTY_LIMIT: duty_limit_q <= cfg_wdata_i[6:0];
        srmcdr_pkg::REG_RAMP_STEP:  ramp_step_q  <= cfg_wdata_i[6:0];
        srmcdr_pkg::REG_PERIOD:     period_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Commutation and ramp for a tick.
  always_comb begin
    sens_any = sensor_one_i || sensor_two_i || sensor_three_i;
    if (!armed_q) begin
      tick_phase = srmcdr_pkg::PH_OFF;
    end else if (sensor_one_i) begin
      tick_phase = srmcdr_pkg::PH_A;
    end else if (sensor_three_i) begin
      tick_phase = srmcdr_pkg::PH_B;
    end else if (sensor_two_i) begin
      tick_phase = srmcdr_pkg::PH_C;
    end else begin
      tick_phase = phase_mem_q;
    end

    base8 = armed_q ? {1'b0, duty_q} : 8'd0;
    step8 = {1'b0, ramp_step_q};
    tgt8  = (target_q > duty_limit_q) ? {1'b0, duty_limit_q} : {1'b0, target_q};
    if (!armed_q || !sens_any) begin
      tgt8 = 8'd0;
    end

    up8 = base8 + step8;
    if (up8 > tgt8) begin
      up8 = tgt8;
    end
    dn8 = (base8 > step8) ? (base8 - step8) : 8'd0;
    if (dn8 < tgt8) begin
      dn8 = tgt8;
    end
    if (base8 < tgt8) begin
      ramp8 = up8;
    end else if (base8 > tgt8) begin
      ramp8 = dn8;
    end else begin
      ramp8 = base8;
    end
  end

  // Command line handling and state update.
  always_comb begin
    is_eol   = (rx_byte_i == srmcdr_pkg::CH_LF) || (rx_byte_i == srmcdr_pkg::CH_CR);
    is_digit = (rx_byte_i >= srmcdr_pkg::CH_0) && (rx_byte_i <= srmcdr_pkg::CH_9);
    is_ws    = (rx_byte_i == srmcdr_pkg::CH_SPACE) || (rx_byte_i == srmcdr_pkg::CH_TAB) ||
               (rx_byte_i == srmcdr_pkg::CH_VT) || (rx_byte_i == srmcdr_pkg::CH_FF);
    is_sign  = (rx_byte_i == srmcdr_pkg::CH_PLUS) || (rx_byte_i == srmcdr_pkg::CH_MINUS);
    acc_next = 12'(acc_q) * 12'd10 + 12'(rx_byte_i - srmcdr_pkg::CH_0);

    armed_d     = armed_q;
    target_d    = target_q;
    duty_d      = duty_q;
    phase_mem_d = phase_mem_q;
    len_d       = len_q;
    first_d     = first_q;
    second_d    = second_q;
    acc_d       = acc_q;
    np_d        = np_q;
    neg_d       = neg_q;

    if (in_fire) begin
      if (!cmd_i) begin
        duty_d = ramp8[6:0];
        if (armed_q && sens_any) begin
          phase_mem_d = tick_phase;
        end
      end else if (is_eol) begin
        if (len_q != '0) begin
          if (first_q == srmcdr_pkg::CH_E) begin
            armed_d = (len_q >= LenW'(2)) && (second_q == srmcdr_pkg::CH_1);
            if (!armed_d) begin
              target_d    = '0;
              duty_d      = '0;
              phase_mem_d = srmcdr_pkg::PH_OFF;
            end
          end else if (first_q == srmcdr_pkg::CH_R) begin
            armed_d = 1'b0;
          end else if (first_q == srmcdr_pkg::CH_P) begin
            if ((!neg_q || acc_q == 8'd0) && acc_q <= {1'b0, srmcdr_pkg::DUTY_MAX}) begin
              target_d = acc_q[6:0];
            end
          end
        end
        len_d    = '0;
        first_d  = '0;
        second_d = '0;
        acc_d    = '0;
        np_d     = srmcdr_pkg::NP_SKIP;
        neg_d    = 1'b0;
      end else if (len_q < LenW'(LINE_CHARS)) begin
        len_d = len_q + LenW'(1);
        if (len_q == '0) begin
          first_d = rx_byte_i;
        end else begin
          if (len_q == LenW'(1)) begin
            second_d = rx_byte_i;
          end
          // Leading whitespace and one sign are taken only before any digit.
          if (np_q == srmcdr_pkg::NP_SKIP && is_ws) begin
            np_d = np_q;
          end else if (np_q == srmcdr_pkg::NP_SKIP && is_sign) begin
            neg_d = (rx_byte_i == srmcdr_pkg::CH_MINUS);
            np_d  = srmcdr_pkg::NP_SIGN;
          end else if (np_q != srmcdr_pkg::NP_DONE && is_digit) begin
            acc_d = (acc_next > 12'(srmcdr_pkg::NUM_SAT)) ? srmcdr_pkg::NUM_SAT : acc_next[7:0];
            np_d  = srmcdr_pkg::NP_DIGIT;
          end else begin
            np_d = srmcdr_pkg::NP_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      target_q    <= '0;
      duty_q      <= '0;
      phase_mem_q <= srmcdr_pkg::PH_OFF;
      len_q       <= '0;
      first_q     <= '0;
      second_q    <= '0;
      acc_q       <= '0;
      np_q        <= srmcdr_pkg::NP_SKIP;
      neg_q       <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      target_q    <= target_d;
      duty_q      <= duty_d;
      phase_mem_q <= phase_mem_d;
      len_q       <= len_d;
      first_q     <= first_d;
      second_q    <= second_d;
      acc_q       <= acc_d;
      np_q        <= np_d;
      neg_q       <= neg_d;
      if (ready_a) begin
        s1_v_q <= in_fire && !cmd_i;
      end
      if (ready_b) begin
        s2_v_q <= s1_v_q;
      end
      if (ready_c) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  assign quot_full = QW'(s2_prod_q) * QW'(srmcdr_pkg::DIV100_RECIP);
  assign cmp       = quot_full[srmcdr_pkg::DIV100_SHIFT +: 16];

  always_ff @(posedge clk_i) begin
    if (ready_a) begin
      s1_phase_q <= tick_phase;
      s1_duty_q  <= ramp8[6:0];
      s1_armed_q <= armed_q;
    end
    if (ready_b) begin
      s2_phase_q <= s1_phase_q;
      s2_duty_q  <= s1_duty_q;
      s2_armed_q <= s1_armed_q;
      s2_prod_q  <= PW'(s1_duty_q) * PW'(period_q);
    end
    if (ready_c) begin
      compare_phase_a_o <= (s2_phase_q == srmcdr_pkg::PH_A) ? cmp : 16'd0;
      compare_phase_b_o <= (s2_phase_q == srmcdr_pkg::PH_B) ? cmp : 16'd0;
      compare_phase_c_o <= (s2_phase_q == srmcdr_pkg::PH_C) ? cmp : 16'd0;
      active_phase_o    <= s2_phase_q;
      duty_now_o        <= s2_duty_q;
      is_armed_o        <= s2_armed_q;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

// ===== design/srmcdr_checker.sv =====
// Port-level checks for the commutation core, bound to the top level.
module srmcdr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] compare_phase_a_o,
  input logic [15:0] compare_phase_b_o,
  input logic [15:0] compare_phase_c_o,
  input logic [1:0]  active_phase_o,
  input logic [6:0]  duty_now_o,
  input logic        is_armed_o
);

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(compare_phase_a_o) &&
    $stable(compare_phase_b_o) && $stable(compare_phase_c_o) && $stable(duty_now_o))
    else $error("result changed while stalled");

  // Only the active phase may carry a compare value.
  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (active_phase_o == srmcdr_pkg::PH_A || compare_phase_a_o == 16'd0) &&
    (active_phase_o == srmcdr_pkg::PH_B || compare_phase_b_o == 16'd0) &&
    (active_phase_o == srmcdr_pkg::PH_C || compare_phase_c_o == 16'd0))
    else $error("compare value on an inactive phase");

  // A disarmed drive reports the phase off and zero duty.
  a_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_armed_o |-> active_phase_o == srmcdr_pkg::PH_OFF &&
    duty_now_o == 7'd0)
    else $error("disarmed drive is driving");

  // The ramped duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_now_o <= srmcdr_pkg::DUTY_MAX)
    else $error("duty above 100 percent");

endmodule

bind srm_commutation_duty_ramp_core srmcdr_checker u_srmcdr_checker (.*);
